@@ sv/sdae_pkg.sv @@
// ============================================================================
// sdae_pkg - shared definitions for the signed decimal ASCII emitter
// Field widths, character codes, controller states and the BCD adjust step.
// ============================================================================
package sdae_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int CHAR_W     = 8;
  localparam int COUNT_W    = 4;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int BITCNT_W   = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Request from the controller to the converter.
  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] mag;
  } conv_req_t;

  // Status from the converter back to the controller.
  typedef struct packed {
    logic done;
    bcd_t bcd;
  } conv_stat_t;

  // Shift-and-add-3 correction of one BCD digit before it is doubled.
  function automatic logic [DIGIT_W-1:0] dabble_adjust(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = (d >= 4'd5) ? d + 4'd3 : d;
    return r;
  endfunction

endpackage

@@ sv/sdae_in_if.sv @@
// ============================================================================
// sdae_in_if - request channel carrying one signed integer
// Valid/ready handshake with a 32-bit two's complement payload.
// ============================================================================
interface sdae_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [sdae_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

@@ sv/sdae_out_if.sv @@
// ============================================================================
// sdae_out_if - character channel
// Valid/ready handshake carrying one ASCII character, a last flag and the
// character count of the whole number.
// ============================================================================
interface sdae_out_if;
  logic                          valid;
  logic                          ready;
  logic [sdae_pkg::CHAR_W-1:0]   text_char;
  logic                          is_last;
  logic [sdae_pkg::COUNT_W-1:0]  char_count;

  modport source (output valid, output text_char, output is_last, output char_count,
                  input ready);
  modport sink   (input valid, input text_char, input is_last, input char_count,
                  output ready);
endinterface

@@ sv/sdae_bcd_conv.sv @@
// ============================================================================
// sdae_bcd_conv - bit-serial binary to BCD converter
// Shifts the magnitude in one bit per cycle with add-3 digit correction.
// ============================================================================
module sdae_bcd_conv (
  input  logic                  clk,
  input  logic                  rst,
  input  sdae_pkg::conv_req_t   req,
  output sdae_pkg::conv_stat_t  stat
);
  import sdae_pkg::*;

  logic [VALUE_W-1:0]  bin;
  bcd_t                bcd;
  bcd_t                bcd_adj;
  logic [BITCNT_W-1:0] bitcnt;
  logic                busy;
  logic                done;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i] = dabble_adjust(bcd[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && bitcnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      bin    <= req.mag;
      bcd    <= '0;
      bitcnt <= BITCNT_W'(VALUE_W - 1);
    end else if (busy) begin
      bcd    <= bcd_t'({bcd_adj[NUM_DIGITS-1:0], bin[VALUE_W-1]});
      bin    <= {bin[VALUE_W-2:0], 1'b0};
      bitcnt <= bitcnt - 1'b1;
    end
  end

  assign stat.done = done;
  assign stat.bcd  = bcd;

endmodule

@@ sv/signed_decimal_ascii_emitter.sv @@
// ============================================================================
// signed_decimal_ascii_emitter - signed 32-bit integer to decimal ASCII text
// Converts one two's complement number at a time into its decimal characters.
// ============================================================================
// One request carries a signed 32-bit value; the block answers with one
// character per output request, most significant first: a leading '-' for a
// negative value, then the digits with leading zeros suppressed (zero gives a
// single '0', the most negative value gives "-2147483648"). Every character
// carries is_last on the final one and char_count, the full length of the
// text including the sign. The block works on one number at a time. The
// magnitude goes through a bit-serial binary to BCD converter, one bit per
// cycle. A number is loaded into the converter, converted, has its leading
// digit found and is then sent one character at a time as the output
// register frees up; the next request is taken only once the last character
// has entered the output register. The last character may still wait in the
// output register while the next number is already being converted.
module signed_decimal_ascii_emitter (
  input  logic        clk,
  input  logic        rst,
  sdae_in_if.sink     number,
  sdae_out_if.source  text
);
  import sdae_pkg::*;

  state_t              state;
  conv_req_t           conv_req;
  conv_stat_t          conv_stat;

  logic                neg;
  logic                sign_pending;
  logic [IDX_W-1:0]    ptr;
  logic [COUNT_W-1:0]  total;
  logic [IDX_W-1:0]    top_idx;
  logic                accept;
  logic                out_free;

  logic                ovalid;
  logic [CHAR_W-1:0]   ochar;
  logic                olast;
  logic [COUNT_W-1:0]  ocount;

  // A request is taken only when no number is in flight.
  assign number.ready = (state == ST_IDLE);
  assign accept       = number.valid && number.ready;

  // Magnitude as an unsigned number, so the most negative value stays exact.
  assign conv_req.start = accept;
  assign conv_req.mag   = number.value[VALUE_W-1] ? (~number.value + 1'b1)
                                                  : number.value;

  sdae_bcd_conv u_conv (
    .clk  (clk),
    .rst  (rst),
    .req  (conv_req),
    .stat (conv_stat)
  );

  // Index of the most significant nonzero digit; zero keeps the units digit.
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (conv_stat.bcd[i] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  // The output register is free when it is empty or being drained this cycle.
  assign out_free = !ovalid || text.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ovalid <= 1'b0;
    end else begin
      if (state == ST_EMIT && out_free) begin
        ovalid <= 1'b1;
      end else if (text.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (conv_stat.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (!sign_pending && ptr == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; the controller above decides when they matter.
  // The count travels with each character, so a character that waits in the
  // output register keeps its own count while the next number converts.
  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= number.value[VALUE_W-1];
    end
    if (state == ST_CONV && conv_stat.done) begin
      ptr          <= top_idx;
      sign_pending <= neg;
      total        <= COUNT_W'(top_idx) + COUNT_W'(1) + COUNT_W'(neg);
    end
    if (state == ST_EMIT && out_free) begin
      ocount <= total;
      if (sign_pending) begin
        ochar        <= CHAR_MINUS;
        olast        <= 1'b0;
        sign_pending <= 1'b0;
      end else begin
        ochar <= CHAR_ZERO + CHAR_W'(conv_stat.bcd[ptr]);
        olast <= (ptr == '0);
        if (ptr != '0) begin
          ptr <= ptr - 1'b1;
        end
      end
    end
  end

  assign text.valid      = ovalid;
  assign text.text_char  = ochar;
  assign text.is_last    = olast;
  assign text.char_count = ocount;

endmodule

@@ sv/sdae_checker.sv @@
// ============================================================================
// sdae_checker - port-level checks for the signed decimal ASCII emitter
// Watches both channels and flags illegal characters and sequencing.
// ============================================================================
module sdae_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sdae_pkg::CHAR_W-1:0]   text_char,
  input logic                          is_last,
  input logic [sdae_pkg::COUNT_W-1:0]  char_count
);
  import sdae_pkg::*;

  // A stalled character must hold still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(text_char) && $stable(is_last)
                                && $stable(char_count))
    else $error("character changed while stalled");

  // Once a number is taken the block is busy converting it.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while conversion in flight");

  // Only a minus sign or a decimal digit ever leaves the block.
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (text_char == CHAR_MINUS) ||
                  (text_char >= CHAR_ZERO && text_char <= CHAR_ZERO + 8'd9))
    else $error("illegal character");

  // The length is always that of a 32-bit signed number.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_count >= 4'd1) && (char_count <= 4'd11))
    else $error("character count out of range");

  // A minus sign is never the last character.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_char == CHAR_MINUS |-> !is_last && char_count >= 4'd2)
    else $error("sign flagged as last character");

endmodule

bind signed_decimal_ascii_emitter sdae_checker u_sdae_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (number.valid),
  .in_ready   (number.ready),
  .out_valid  (text.valid),
  .out_ready  (text.ready),
  .text_char  (text.text_char),
  .is_last    (text.is_last),
  .char_count (text.char_count)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb - self-checking bench for the signed decimal ASCII emitter
// Sends signed 32-bit numbers with random gaps, predicts every character of
// their decimal text and checks each one against the character channel.
// ============================================================================
module tb;
  import sdae_pkg::*;

  // The quiet limit is far above the slowest legal gap between two accepted
  // requests: the conversion of a number plus long random stalls on both sides.
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 230;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [CHAR_W-1:0]  text_char;
    logic               is_last;
    logic [COUNT_W-1:0] char_count;
  } text_char_t;

  // Holds the characters still owed by the block, oldest first, and grades
  // every character that comes out against them.
  class ascii_scoreboard;
    text_char_t owed_chars[$];
    int         errors;

    function void add_number(logic [VALUE_W-1:0] raw);
      logic [VALUE_W-1:0] mag;
      logic [DIGIT_W-1:0] digits [NUM_DIGITS];
      logic [COUNT_W-1:0] total;
      text_char_t         c;
      int                 ndig;
      bit                 negative;
      negative = raw[VALUE_W-1];
      // The magnitude is taken as unsigned, so the most negative value keeps
      // its full size of 2147483648.
      mag  = negative ? (~raw + 1'b1) : raw;
      ndig = 0;
      do begin
        digits[ndig] = DIGIT_W'(mag % 10);
        ndig++;
        mag = mag / 10;
      end while (mag != 0 && ndig < NUM_DIGITS);
      total = COUNT_W'(ndig + int'(negative));
      if (negative) begin
        c = '{CHAR_MINUS, 1'b0, total};
        owed_chars.push_back(c);
      end
      for (int i = ndig; i > 0; i--) begin
        c = '{CHAR_ZERO + CHAR_W'(digits[i-1]), (i == 1), total};
        owed_chars.push_back(c);
      end
    endfunction

    function void grade_char(logic [CHAR_W-1:0] ch, logic last, logic [COUNT_W-1:0] count);
      text_char_t want;
      if (owed_chars.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: character %0d last %0b count %0d arrived with none expected",
                   $realtime, ch, last, count);
        return;
      end
      want = owed_chars.pop_front();
      if (ch !== want.text_char || last !== want.is_last || count !== want.char_count) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: expected char %0d last %0b count %0d, got char %0d last %0b count %0d",
                   $realtime, want.text_char, want.is_last, want.char_count, ch, last, count);
      end
    endfunction

    function int owed();
      return owed_chars.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   no_idle;   // set for a stretch in which neither side pauses
  int   quiet_cycles;

  ascii_scoreboard sb = new();

  sdae_in_if  number_ch ();
  sdae_out_if text_ch ();

  signed_decimal_ascii_emitter i_dut (
    .clk    (clk),
    .rst    (rst),
    .number (number_ch.sink),
    .text   (text_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Every input of the block is driven from time zero on.
  initial begin
    rst             = 1'b1;
    number_ch.valid = 1'b0;
    number_ch.value = '0;
    text_ch.ready   = 1'b0;
  end

  // The character sink stalls in each cycle with a chance of 29 in 100, except during the
  // no-idle stretch. It changes only at the falling edge.
  always @(negedge clk) begin
    text_ch.ready = !rst && (no_idle || $urandom_range(99) >= 29);
  end

  // Both channels are sampled at the rising edge. A number that is accepted
  // is turned into its expected characters at once; the block cannot answer
  // within the same cycle, so noting it before grading output is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (number_ch.valid && number_ch.ready)
        sb.add_number(number_ch.value);
      if (text_ch.valid && text_ch.ready)
        sb.grade_char(text_ch.text_char, text_ch.is_last, text_ch.char_count);
    end
  end

  // The watchdog ends a run in which nothing moves on either channel for too
  // long, which catches a hung handshake as well as a lost character.
  always @(posedge clk) begin
    if (rst || (number_ch.valid && number_ch.ready) || (text_ch.valid && text_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offers one number, possibly after a few idle cycles with junk on the bus,
  // and returns at the falling edge after the request has been taken.
  task automatic send_number(input logic [VALUE_W-1:0] v);
    while (!no_idle && $urandom_range(99) < 29) begin
      number_ch.valid = 1'b0;
      number_ch.value = $urandom;
      @(negedge clk);
    end
    number_ch.valid = 1'b1;
    number_ch.value = v;
    do @(posedge clk); while (!number_ch.ready);
    @(negedge clk);
  endtask

  // Holds the sender off until the block has delivered every character owed.
  task automatic drain_text();
    number_ch.valid = 1'b0;
    while (sb.owed() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Random numbers come in four flavors: any 32-bit pattern, a number of a
  // chosen decimal length so that every length shows up often, small values
  // around zero, and values right at the range limits or at powers of ten.
  function automatic logic [VALUE_W-1:0] random_number();
    int unsigned p;
    int unsigned lo;
    int unsigned hi;
    int unsigned len;
    logic [VALUE_W-1:0] mag;
    case ($urandom_range(3))
      0: return $urandom;
      1: begin
        len = $urandom_range(10, 1);
        p   = 1;
        repeat (len - 1) p *= 10;
        lo  = (len == 1) ? 0 : p;
        hi  = (len == 10) ? 32'h7fff_ffff : p * 10 - 1;
        mag = $urandom_range(hi, lo);
        return $urandom_range(1) ? -mag : mag;
      end
      2: return VALUE_W'($signed($urandom_range(400)) - 200);
      default: begin
        case ($urandom_range(2))
          0: return 32'h8000_0000 + $urandom_range(5);
          1: return 32'h7fff_ffff - $urandom_range(5);
          default: begin
            p = 1;
            repeat ($urandom_range(9)) p *= 10;
            mag = p + $urandom_range(2) - 1;
            return $urandom_range(1) ? -mag : mag;
          end
        endcase
      end
    endcase
  endfunction

  // Directed numbers: zero, single digits, digit lengths 1, 2, 3, 5, 9 and 10, both range
  // limits, the most negative value, all-ones and alternating bit patterns.
  logic [VALUE_W-1:0] directed_numbers [] = '{
    32'd0, 32'd1, -32'd1, 32'd9, -32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
    -32'd12345, 32'd12345, 32'd999_999_999, -32'd999_999_999,
    32'd1_000_000_000, -32'd1_000_000_000, 32'd1_234_567_890, -32'd1_234_567_890,
    32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'h5555_5555, 32'haaaa_aaaa,
    32'hffff_fff6
  };

  initial begin
    no_idle = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_numbers[i])
      send_number(directed_numbers[i]);

    // Let the block run dry once before the random part starts.
    drain_text();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 80 && n < 130);
      if (n == 160)
        drain_text();
      send_number(random_number());
    end
    no_idle         = 1'b0;
    number_ch.valid = 1'b0;

    // Wait for the last characters, then give the block time to show any
    // character it should not send at all.
    while (sb.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.owed() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
